>>> hw/rtl/template_tag_splitter_top_macros.svh
// ----------------------------------------------------------------------------
// Template tag splitter assertion macros
// Shared property wrappers for the checker; clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef TEMPLATE_TAG_SPLITTER_TOP_MACROS_SVH
`define TEMPLATE_TAG_SPLITTER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TTS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// Template tag splitter package
// Shared constants, result types and helpers for the splitter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

  localparam int MAX_TAG_BYTES_DEF = 8;
  localparam int POSITION_BITS_DEF = 20;
  localparam int SEG_POS_BITS      = 20;
  localparam int CFG_DATA_BITS     = 64;
  localparam int CFG_INDEX_BITS    = 2;
  localparam int CFG_LEN_BITS      = 4;
  localparam int QUEUE_DEPTH       = 4;
  localparam int QUEUE_PTR_BITS    = $clog2(QUEUE_DEPTH);

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_CODE = 1'b1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_OPEN_TAG  = 2'd0,
    CFG_OPEN_LEN  = 2'd1,
    CFG_CLOSE_TAG = 2'd2,
    CFG_CLOSE_LEN = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic                    final_segment;
    logic                    unclosed;
    logic [SEG_POS_BITS-1:0] seg_finish;
    logic [SEG_POS_BITS-1:0] seg_begin;
    logic                    segment_kind;
  } seg_res_t;

  typedef struct packed {
    logic     two;
    seg_res_t second;
    seg_res_t first;
  } seg_entry_t;

  function automatic logic [SEG_POS_BITS-1:0] out_pos(input logic [31:0] pos);
    return pos[SEG_POS_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tts_front.sv
// ----------------------------------------------------------------------------
// Template tag splitter front end
// Holds the configuration, matches tags over the byte window and builds the
// segment results caused by each accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_front #(
  parameter int MAX_TAG_BYTES = tts_pkg::MAX_TAG_BYTES_DEF,
  parameter int POSITION_BITS = tts_pkg::POSITION_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  input  wire logic [tts_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  wire logic [tts_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  output logic                                     cfg_ready_o,
  input  wire logic                                byte_valid_i,
  input  wire logic [7:0]                          byte_value_i,
  input  wire logic                                last_byte_i,
  output logic                                     byte_ready_o,
  input  wire logic                                queue_full_i,
  output logic                                     push_o,
  output tts_pkg::seg_entry_t                      entry_o
);

  localparam int W  = 8 * MAX_TAG_BYTES;
  localparam int CW = $clog2(MAX_TAG_BYTES + 1);
  localparam int IW = (MAX_TAG_BYTES > 1) ? $clog2(MAX_TAG_BYTES) : 1;
  localparam int PW = POSITION_BITS;

  logic [tts_pkg::CFG_DATA_BITS-1:0] open_tag_q, close_tag_q;
  logic [tts_pkg::CFG_LEN_BITS-1:0]  open_len_q, close_len_q;

  logic [W-1:0]  win_q, win_d;
  logic          code_q, code_d;
  logic [PW-1:0] seg_q, seg_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic [W+7:0]                      win_wide;
  logic [W-1:0]                      win_sh;
  logic [CW-1:0]                     cnt_inc;
  logic [tts_pkg::CFG_LEN_BITS-1:0]  len_raw;
  logic [CW-1:0]                     len_eff;
  logic [tts_pkg::CFG_DATA_BITS-1:0] tag_sel;
  logic [IW-1:0]                     lane_idx;
  logic                              lanes_ok;
  logic                              match;
  logic [PW-1:0]                     pos_end;
  logic [PW:0]                       start_plus;
  logic [PW-1:0]                     tag_start;
  logic                              r0_valid;
  logic                              code_nx;
  logic [PW-1:0]                     seg_nx;
  logic                              accept;
  tts_pkg::seg_res_t                 res0, resf;

  assign cfg_ready_o  = 1'b1;
  assign byte_ready_o = !queue_full_i;
  assign accept       = byte_valid_i && byte_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_tag_q  <= '0;
      close_tag_q <= '0;
      open_len_q  <= tts_pkg::CFG_LEN_BITS'(1);
      close_len_q <= tts_pkg::CFG_LEN_BITS'(1);
    end else if (cfg_valid_i) begin
      case (tts_pkg::cfg_reg_e'(cfg_index_i))
        tts_pkg::CFG_OPEN_TAG:  open_tag_q  <= cfg_data_i;
        tts_pkg::CFG_OPEN_LEN:  open_len_q  <= cfg_data_i[tts_pkg::CFG_LEN_BITS-1:0];
        tts_pkg::CFG_CLOSE_TAG: close_tag_q <= cfg_data_i;
        tts_pkg::CFG_CLOSE_LEN: close_len_q <= cfg_data_i[tts_pkg::CFG_LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      code_q <= 1'b0;
      seg_q  <= '0;
      pos_q  <= '0;
      cnt_q  <= '0;
    end else begin
      win_q  <= win_d;
      code_q <= code_d;
      seg_q  <= seg_d;
      pos_q  <= pos_d;
      cnt_q  <= cnt_d;
    end
  end

  always_comb begin
    win_wide = {byte_value_i, win_q};
    win_sh   = win_wide[W+7:8];
    cnt_inc  = (cnt_q < CW'(MAX_TAG_BYTES)) ? cnt_q + CW'(1) : cnt_q;
    len_raw  = code_q ? close_len_q : open_len_q;
    tag_sel  = code_q ? close_tag_q : open_tag_q;
    if (len_raw == '0) begin
      len_eff = CW'(1);
    end else if (len_raw > tts_pkg::CFG_LEN_BITS'(MAX_TAG_BYTES)) begin
      len_eff = CW'(MAX_TAG_BYTES);
    end else begin
      len_eff = CW'(len_raw);
    end

    lanes_ok = 1'b1;
    lane_idx = '0;
    for (int k = 0; k < MAX_TAG_BYTES; k++) begin
      if (k < int'(len_eff)) begin
        lane_idx = IW'(MAX_TAG_BYTES + k - int'(len_eff));
        if (win_sh[8*lane_idx +: 8] != tag_sel[8*k +: 8]) begin
          lanes_ok = 1'b0;
        end
      end
    end
    match = (cnt_inc >= len_eff) && lanes_ok;

    pos_end    = (pos_q != '1) ? pos_q + PW'(1) : pos_q;
    start_plus = {1'b0, seg_q} + (PW+1)'(len_eff);
    tag_start  = ({1'b0, pos_end} >= start_plus) ? pos_end - PW'(len_eff) : seg_q;

    r0_valid = match && (code_q || (tag_start != seg_q));
    code_nx  = match ? !code_q : code_q;
    seg_nx   = match ? pos_end : seg_q;

    res0.segment_kind  = code_q;
    res0.seg_begin     = tts_pkg::out_pos(32'(seg_q));
    res0.seg_finish    = tts_pkg::out_pos(32'(tag_start));
    res0.unclosed      = 1'b0;
    res0.final_segment = 1'b0;

    resf.segment_kind  = code_nx;
    resf.seg_begin     = tts_pkg::out_pos(32'(seg_nx));
    resf.seg_finish    = tts_pkg::out_pos(32'(pos_end));
    resf.unclosed      = code_nx;
    resf.final_segment = 1'b1;

    if (r0_valid) begin
      entry_o.first  = res0;
      entry_o.second = resf;
      entry_o.two    = last_byte_i;
    end else begin
      entry_o.first  = resf;
      entry_o.second = resf;
      entry_o.two    = 1'b0;
    end
    push_o = accept && (r0_valid || last_byte_i);

    win_d  = win_q;
    code_d = code_q;
    seg_d  = seg_q;
    pos_d  = pos_q;
    cnt_d  = cnt_q;
    if (accept) begin
      if (last_byte_i) begin
        win_d  = '0;
        code_d = 1'b0;
        seg_d  = '0;
        pos_d  = '0;
        cnt_d  = '0;
      end else begin
        win_d  = win_sh;
        code_d = code_nx;
        seg_d  = seg_nx;
        pos_d  = pos_end;
        cnt_d  = match ? '0 : cnt_inc;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tts_queue.sv
// ----------------------------------------------------------------------------
// Template tag splitter result queue
// Small first-in first-out buffer of result entries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire tts_pkg::seg_entry_t  wdata_i,
  input  wire logic                 pop_i,
  output tts_pkg::seg_entry_t       rdata_o,
  output logic                      full_o,
  output logic                      empty_o
);

  localparam int PB = tts_pkg::QUEUE_PTR_BITS;

  tts_pkg::seg_entry_t mem_q [tts_pkg::QUEUE_DEPTH];
  logic [PB-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [PB:0]         cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == (PB+1)'(tts_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + PB'(1) : wr_q;
    rd_d  = do_pop ? rd_q + PB'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (PB+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (PB+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tts_back.sv
// ----------------------------------------------------------------------------
// Template tag splitter back end
// Unpacks queued entries into single result words on a registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire tts_pkg::seg_entry_t  entry_i,
  input  wire logic                 empty_i,
  output logic                      pop_o,
  output logic                      res_valid_o,
  output tts_pkg::seg_res_t         res_o,
  input  wire logic                 res_ready_i
);

  logic              out_valid_q, out_valid_d;
  logic              pend_valid_q, pend_valid_d;
  tts_pkg::seg_res_t out_q, out_d;
  tts_pkg::seg_res_t pend_q, pend_d;
  logic              load;

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;
  assign load        = !out_valid_q || res_ready_i;
  assign pop_o       = load && !pend_valid_q && !empty_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    if (load) begin
      if (pend_valid_q) begin
        out_d        = pend_q;
        out_valid_d  = 1'b1;
        pend_valid_d = 1'b0;
      end else if (!empty_i) begin
        out_d        = entry_i.first;
        out_valid_d  = 1'b1;
        pend_d       = entry_i.second;
        pend_valid_d = entry_i.two;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

endmodule

`default_nettype wire

>>> hw/rtl/template_tag_splitter_top.sv
// ----------------------------------------------------------------------------
// Template tag splitter top level
// Splits a byte stream into plain data and code segments at open and close
// tags, reporting each segment as one result word.
//
//   Channel   Dir  Payload
//   s_axis    in   tdata[7:0] byte_value, tlast last_byte
//   m_axis    out  tdata[19:0] seg_begin, tdata[39:20] seg_finish,
//                  tuser[0] segment_kind, tuser[1] unclosed, tlast final_segment
//   cfg       in   cfg_index_i register index, cfg_data_i write data
//
// One byte is accepted per cycle unless the result queue is full; the tag
// compare over the byte window is done in the same cycle as the accept.
// A result passes the result queue and then the output register to m_axis.
// A byte that causes two results occupies the output register for two words.
// s_axis stalls only when the four-entry result queue is full.
// Reset is asynchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module template_tag_splitter_top #(
  parameter int MAX_TAG_BYTES = tts_pkg::MAX_TAG_BYTES_DEF,
  parameter int POSITION_BITS = tts_pkg::POSITION_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [tts_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  wire logic [tts_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [7:0]                         s_axis_tdata,  // byte_value
  input  wire logic                               s_axis_tlast,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [39:0]                             m_axis_tdata,  // seg_begin, seg_finish
  output logic [1:0]                              m_axis_tuser,  // segment_kind, unclosed
  output logic                                    m_axis_tlast
);

  tts_pkg::seg_entry_t push_entry, head_entry;
  tts_pkg::seg_res_t   res;
  logic                push, pop, q_full, q_empty;

  tts_front #(
    .MAX_TAG_BYTES(MAX_TAG_BYTES),
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .byte_valid_i(s_axis_tvalid),
    .byte_value_i(s_axis_tdata),
    .last_byte_i (s_axis_tlast),
    .byte_ready_o(s_axis_tready),
    .queue_full_i(q_full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  tts_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(push_entry),
    .pop_i  (pop),
    .rdata_o(head_entry),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  tts_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .entry_i    (head_entry),
    .empty_i    (q_empty),
    .pop_o      (pop),
    .res_valid_o(m_axis_tvalid),
    .res_o      (res),
    .res_ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {res.seg_finish, res.seg_begin};
  assign m_axis_tuser = {res.unclosed, res.segment_kind};
  assign m_axis_tlast = res.final_segment;

endmodule

`default_nettype wire

>>> hw/rtl/tts_checker.sv
// ----------------------------------------------------------------------------
// Template tag splitter port checker
// Watches the top-level ports for output stability and segment sanity.
// ----------------------------------------------------------------------------
`default_nettype none

`include "template_tag_splitter_top_macros.svh"

module tts_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  `TTS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "Stalled result word changed")
  `TTS_ASSERT_SAME(a_order, m_axis_tvalid, m_axis_tdata[19:0] <= m_axis_tdata[39:20], "Segment ends before it begins")
  `TTS_ASSERT_SAME(a_unclosed, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0] && m_axis_tlast, "Unclosed flag on a data or non-final segment")
  `TTS_ASSERT_SAME(a_data_nonempty, m_axis_tvalid && !m_axis_tuser[0] && !m_axis_tlast, m_axis_tdata[19:0] != m_axis_tdata[39:20], "Empty data segment before an open tag")

endmodule

bind template_tag_splitter_top tts_checker u_tts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire
